// File: hw/rtl/tcw_pkg.sv
// shared constants and command/status types for the text console writer
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_STEPS = 4;
    localparam int CELLS     = COLUMNS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int OP_W   = 2;
    localparam int CELL_W = CHAR_W + 2 * CLR_W;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = ROW_W + COL_W;
    localparam int STEP_W = $clog2(TAB_STEPS + 1);
    localparam int CIDX_W = 1;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    localparam logic [CIDX_W-1:0] REG_FOREGROUND = 1'd0;
    localparam logic [CIDX_W-1:0] REG_BACKGROUND = 1'd1;

    localparam logic [CLR_W-1:0] FG_RESET = 4'd10;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic capture;
        logic write_char;
        logic read_cell;
        logic advance;
        logic new_row;
        logic scroll_rd;
        logic clear_wr;
        logic home;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op_clear;
        logic op_read;
        logic put_nl;
        logic put_char;
        logic steps_zero;
        logic col_last;
        logic row_last;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/tcw_ctrl.sv
// controller state machine for the text console writer
module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tcw_pkg::t_dp_stat i_stat,
    output tcw_pkg::t_dp_cmd  o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [8:0] {
        S_INIT       = 9'b000000001,
        S_IDLE       = 9'b000000010,
        S_DECODE     = 9'b000000100,
        S_ADV        = 9'b000001000,
        S_NEWROW     = 9'b000010000,
        S_SCROLL     = 9'b000100000,
        S_SCROLL_END = 9'b001000000,
        S_CLEAR      = 9'b010000000,
        S_DONE       = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                // clearing pass over the cell store after reset
                o_cmd.clear_wr = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.op_clear) begin
                    n_state = S_CLEAR;
                end else if (i_stat.op_read) begin
                    o_cmd.read_cell = 1'b1;
                    n_state         = S_DONE;
                end else if (i_stat.put_nl) begin
                    n_state = S_NEWROW;
                end else if (i_stat.put_char) begin
                    o_cmd.write_char = 1'b1;
                    n_state          = S_ADV;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                if (i_stat.steps_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    if (i_stat.col_last) begin
                        n_state = S_NEWROW;
                    end
                end
            end
            S_NEWROW: begin
                o_cmd.new_row = 1'b1;
                n_state       = i_stat.row_last ? S_SCROLL : S_ADV;
            end
            S_SCROLL: begin
                o_cmd.scroll_rd = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_SCROLL_END;
                end
            end
            S_SCROLL_END: begin
                // last pending copy write lands here
                n_state = S_ADV;
            end
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.home = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// File: hw/rtl/tcw_dp.sv
// datapath: cell store, cursor, colour registers and result register
module tcw_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcw_pkg::t_dp_cmd               i_cmd,
    output tcw_pkg::t_dp_stat              o_stat,
    input  logic [tcw_pkg::OP_W-1:0]       i_in_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_in_char_code,
    input  logic [tcw_pkg::COL_W-1:0]      i_in_read_column,
    input  logic [tcw_pkg::ROW_W-1:0]      i_in_read_row,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]      i_cfg_data,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_out_printed,
    output logic [tcw_pkg::COL_W-1:0]      o_out_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]      o_out_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]     o_out_cell_char,
    output logic [tcw_pkg::CLR_W-1:0]      o_out_cell_foreground,
    output logic [tcw_pkg::CLR_W-1:0]      o_out_cell_background
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [COL_W-1:0]  r_rc;
    logic [ROW_W-1:0]  r_rr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CLR_W-1:0]  r_fg;
    logic [CLR_W-1:0]  r_bg;
    logic [STEP_W-1:0] r_steps;
    logic [ADDR_W-1:0] r_walk;
    logic              r_printed;
    logic [CELL_W-1:0] r_rdata;
    logic              r_rd_zero;
    logic              r_copy_pend;
    logic [ADDR_W-1:0] r_copy_addr;
    logic              r_out_valid;
    logic              r_out_printed;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CELL_W-1:0] r_out_cell;

    logic              in_char;
    logic [STEP_W-1:0] n_steps;
    logic [ADDR_W-1:0] cur_addr;
    logic [LIN_W-1:0]  rd_lin;
    logic              rd_in_range;
    logic              walk_blank;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [CELL_W-1:0] cell_q;

    // steps to advance, set from the incoming byte
    assign in_char = (i_in_operation == OP_PUT) && (i_in_char_code != CH_NUL)
                     && (i_in_char_code != CH_TAB) && (i_in_char_code != CH_NEWLINE);
    always_comb begin
        priority if ((i_in_operation == OP_PUT) && (i_in_char_code == CH_TAB)) begin
            n_steps = STEP_W'(TAB_STEPS);
        end else if (in_char) begin
            n_steps = STEP_W'(1);
        end else begin
            n_steps = '0;
        end
    end

    assign cur_addr    = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign rd_lin      = LIN_W'(r_rr) * LIN_W'(COLUMNS) + LIN_W'(r_rc);
    assign rd_in_range = ({1'b0, r_rc} < (COL_W + 1)'(COLUMNS))
                         && ({1'b0, r_rr} < (ROW_W + 1)'(ROWS));
    assign walk_blank  = (r_walk >= ADDR_W'(CELLS - COLUMNS));

    assign rd_en   = i_cmd.read_cell | i_cmd.scroll_rd;
    assign rd_addr = i_cmd.scroll_rd ? (walk_blank ? r_walk : r_walk + ADDR_W'(COLUMNS))
                                     : rd_lin[ADDR_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = {r_bg, r_fg, r_ch};
        priority if (r_copy_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_copy_addr;
            wr_data = cell_q;
        end else if (i_cmd.write_char) begin
            wr_en = 1'b1;
        end else if (i_cmd.clear_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_walk;
            wr_data = '0;
        end
    end

    assign cell_q = r_rd_zero ? '0 : r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // payload capture, read-side flags, copy address and result register loads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_in_operation;
            r_ch <= i_in_char_code;
            r_rc <= i_in_read_column;
            r_rr <= i_in_read_row;
        end
        if (rd_en) begin
            r_rd_zero <= i_cmd.scroll_rd ? walk_blank : !rd_in_range;
        end
        r_copy_addr <= r_walk;
        if (i_cmd.out_load) begin
            r_out_printed <= r_printed;
            r_out_col     <= r_col;
            r_out_row     <= r_row;
            r_out_cell    <= (r_op == OP_READ) ? cell_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
            r_steps     <= '0;
            r_walk      <= '0;
            r_printed   <= 1'b0;
            r_copy_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FOREGROUND: r_fg <= i_cfg_data;
                    REG_BACKGROUND: r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_steps   <= n_steps;
                r_printed <= 1'b0;
            end else if (i_cmd.advance) begin
                r_steps <= r_steps - STEP_W'(1);
            end
            if (i_cmd.write_char) begin
                r_printed <= 1'b1;
            end
            if (i_cmd.advance && !o_stat.col_last) begin
                r_col <= r_col + COL_W'(1);
            end
            if (i_cmd.new_row || i_cmd.home) begin
                r_col <= '0;
            end
            if (i_cmd.new_row && !o_stat.row_last) begin
                r_row <= r_row + ROW_W'(1);
            end
            if (i_cmd.home) begin
                r_row <= '0;
            end
            if (i_cmd.scroll_rd || i_cmd.clear_wr) begin
                r_walk <= o_stat.walk_last ? '0 : r_walk + ADDR_W'(1);
            end
            r_copy_pend <= i_cmd.scroll_rd;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.op_clear   = (r_op == OP_CLEAR);
    assign o_stat.op_read    = (r_op == OP_READ);
    assign o_stat.put_nl     = (r_op == OP_PUT) && (r_ch == CH_NEWLINE);
    assign o_stat.put_char   = (r_op == OP_PUT) && (r_ch != CH_NUL) && (r_ch != CH_TAB)
                               && (r_ch != CH_NEWLINE);
    assign o_stat.steps_zero = (r_steps == '0);
    assign o_stat.col_last   = (r_col == COL_W'(COLUMNS - 1));
    assign o_stat.row_last   = (r_row == ROW_W'(ROWS - 1));
    assign o_stat.walk_last  = (r_walk == ADDR_W'(CELLS - 1));
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid           = r_out_valid;
    assign o_out_printed         = r_out_printed;
    assign o_out_cursor_column   = r_out_col;
    assign o_out_cursor_row      = r_out_row;
    assign o_out_cell_char       = r_out_cell[CHAR_W-1:0];
    assign o_out_cell_foreground = r_out_cell[CHAR_W +: CLR_W];
    assign o_out_cell_background = r_out_cell[CHAR_W + CLR_W +: CLR_W];

endmodule

// File: hw/rtl/text_console_writer_core.sv
// top level of the text console writer
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-----------------------------------------
//  in       | i_in_valid / o_in_stall          | operation, char_code, read_column/row
//  out      | o_out_valid / i_out_stall        | printed, cursor, cell char/fg/bg
//  cfg      | i_cfg_we (no wait)               | i_cfg_index, i_cfg_data
//
// one item at a time: a read goes from decode to the result, null bytes and unused ops
// only check the step count, a printed char is written and the cursor advanced, a tab
// advances TAB_STEPS columns and a newline starts a new row, all set by the controller steps
// a scroll walks the cell store once, moving rows up and blanking the last; clear walks it too
// after reset a clearing pass over the cell store runs with o_in_stall high
// a finished result sits in the output register while the next item is taken
module text_console_writer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]       i_in_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_in_char_code,
    input  logic [tcw_pkg::COL_W-1:0]      i_in_read_column,
    input  logic [tcw_pkg::ROW_W-1:0]      i_in_read_row,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_out_printed,
    output logic [tcw_pkg::COL_W-1:0]      o_out_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]      o_out_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]     o_out_cell_char,
    output logic [tcw_pkg::CLR_W-1:0]      o_out_cell_foreground,
    output logic [tcw_pkg::CLR_W-1:0]      o_out_cell_background,
    input  logic                           i_cfg_we,
    input  logic [tcw_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]      i_cfg_data
);
    import tcw_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcw_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_in_operation        (i_in_operation),
        .i_in_char_code        (i_in_char_code),
        .i_in_read_column      (i_in_read_column),
        .i_in_read_row         (i_in_read_row),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_out_printed         (o_out_printed),
        .o_out_cursor_column   (o_out_cursor_column),
        .o_out_cursor_row      (o_out_cursor_row),
        .o_out_cell_char       (o_out_cell_char),
        .o_out_cell_foreground (o_out_cell_foreground),
        .o_out_cell_background (o_out_cell_background)
    );

endmodule

// File: hw/rtl/tcw_checker.sv
// port-level checks for the text console writer, bound to the top level
module tcw_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_out_printed,
    input logic [tcw_pkg::COL_W-1:0]  o_out_cursor_column,
    input logic [tcw_pkg::ROW_W-1:0]  o_out_cursor_row,
    input logic [tcw_pkg::CHAR_W-1:0] o_out_cell_char,
    input logic [tcw_pkg::CLR_W-1:0]  o_out_cell_foreground,
    input logic [tcw_pkg::CLR_W-1:0]  o_out_cell_background
);
    import tcw_pkg::*;

    // clearing pass holds input off right after reset
    a_init_stall: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item in flight: a transfer closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    a_print_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_printed |->
            o_out_cell_char == '0 && o_out_cell_foreground == '0
            && o_out_cell_background == '0)
        else $error("printed result carries cell data");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_cursor_column} < (COL_W + 1)'(COLUMNS))
            && ({1'b0, o_out_cursor_row} < (ROW_W + 1)'(ROWS)))
        else $error("cursor off screen");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_cursor_column)
            && $stable(o_out_cursor_row) && $stable(o_out_cell_char))
        else $error("stalled result changed");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in_valid),
    .o_in_stall            (o_in_stall),
    .o_out_valid           (o_out_valid),
    .i_out_stall           (i_out_stall),
    .o_out_printed         (o_out_printed),
    .o_out_cursor_column   (o_out_cursor_column),
    .o_out_cursor_row      (o_out_cursor_row),
    .o_out_cell_char       (o_out_cell_char),
    .o_out_cell_foreground (o_out_cell_foreground),
    .o_out_cell_background (o_out_cell_background)
);

// File: verif/text_console_writer_core_test.sv
// self-checking regression bench for the text console writer core
`timescale 1ns / 100ps

module text_console_writer_core_test;
    import tcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RAND_ITEMS     = 1150;
    localparam int PHASES         = 5;
    localparam int HEAVY_BUDGET   = 280;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int DIR_N          = 26;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_console_cmd;

    typedef struct packed {
        logic              printed;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] ch;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
    } t_console_res;

    typedef struct packed {
        logic [CLR_W-1:0]  bg;
        logic [CLR_W-1:0]  fg;
        logic [CHAR_W-1:0] ch;
    } t_cell;

    typedef struct packed {
        t_console_cmd cmd;
        logic         typed;
        t_console_res res;
    } t_stim_row;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_in_operation   = '0;
    logic [CHAR_W-1:0]   i_in_char_code   = '0;
    logic [COL_W-1:0]    i_in_read_column = '0;
    logic [ROW_W-1:0]    i_in_read_row    = '0;
    logic                o_out_valid;
    logic                i_out_stall      = 1'b0;
    logic                o_out_printed;
    logic [COL_W-1:0]    o_out_cursor_column;
    logic [ROW_W-1:0]    o_out_cursor_row;
    logic [CHAR_W-1:0]   o_out_cell_char;
    logic [CLR_W-1:0]    o_out_cell_foreground;
    logic [CLR_W-1:0]    o_out_cell_background;
    logic                i_cfg_we         = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_index      = '0;
    logic [CLR_W-1:0]    i_cfg_data       = '0;

    // shadow of the console: cell store, cursor and colour registers
    t_cell               screen [CELLS];
    logic [COL_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic [CLR_W-1:0]    fg_reg;
    logic [CLR_W-1:0]    bg_reg;

    t_console_res        pending_res [$];
    int                  fail_cnt     = 0;
    int                  items_sent   = 0;
    int                  results_seen = 0;
    int                  rand_done    = 0;
    int                  scroll_cnt   = 0;
    int                  clear_cnt    = 0;
    int                  heavy_cnt    = 0;
    int                  quiet_cycles = 0;
    int                  stall_left   = 0;
    bit                  calm         = 1'b0;

    logic [CLR_W-1:0]    fg_plan [PHASES] = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd7};
    logic [CLR_W-1:0]    bg_plan [PHASES] = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd7};

    t_stim_row stim_tab [DIR_N] = '{
        '{'{OP_READ,   CH_NUL,     7'd0,   5'd0},  1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   CH_NUL,     7'd79,  5'd24}, 1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   8'hFF,      7'd127, 5'd31}, 1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   CH_NUL,     7'd80,  5'd0},  1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    8'h41,      7'd0,   5'd0},  1'b1, '{1'b1, 7'd1, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   CH_NUL,     7'd0,   5'd0},  1'b1, '{1'b0, 7'd1, 5'd0, 8'h41, 4'd10, 4'd0}},
        '{'{OP_PUT,    CH_NUL,     7'd127, 5'd31}, 1'b1, '{1'b0, 7'd1, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_UNUSED, 8'hFF,      7'd127, 5'd31}, 1'b1, '{1'b0, 7'd1, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    CH_TAB,     7'd0,   5'd0},  1'b1, '{1'b0, 7'd5, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    8'hFF,      7'd0,   5'd0},  1'b1, '{1'b1, 7'd6, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    8'h01,      7'd0,   5'd0},  1'b1, '{1'b1, 7'd7, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   CH_NUL,     7'd5,   5'd0},  1'b1, '{1'b0, 7'd7, 5'd0, 8'hFF, 4'd10, 4'd0}},
        '{'{OP_PUT,    CH_NEWLINE, 7'd0,   5'd0},  1'b1, '{1'b0, 7'd0, 5'd1, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    8'h80,      7'd0,   5'd0},  1'b1, '{1'b1, 7'd1, 5'd1, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    8'h7F,      7'd0,   5'd0},  1'b0, '0},
        '{'{OP_READ,   CH_NUL,     7'd1,   5'd1},  1'b0, '0},
        '{'{OP_READ,   CH_NUL,     7'd0,   5'd25}, 1'b1, '{1'b0, 7'd2, 5'd1, 8'h00, 4'd0, 4'd0}},
        '{'{OP_CLEAR,  CH_NUL,     7'd0,   5'd0},  1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   CH_NUL,     7'd0,   5'd1},  1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_READ,   CH_NUL,     7'd0,   5'd0},  1'b1, '{1'b0, 7'd0, 5'd0, 8'h00, 4'd0, 4'd0}},
        '{'{OP_PUT,    CH_TAB,     7'd0,   5'd0},  1'b0, '0},
        '{'{OP_PUT,    CH_TAB,     7'd0,   5'd0},  1'b0, '0},
        '{'{OP_PUT,    8'h7A,      7'd0,   5'd0},  1'b0, '0},
        '{'{OP_READ,   CH_NUL,     7'd8,   5'd0},  1'b0, '0},
        '{'{OP_UNUSED, CH_NUL,     7'd0,   5'd0},  1'b0, '0},
        '{'{OP_PUT,    CH_NEWLINE, 7'd0,   5'd0},  1'b0, '0}
    };

    text_console_writer_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_in_operation        (i_in_operation),
        .i_in_char_code        (i_in_char_code),
        .i_in_read_column      (i_in_read_column),
        .i_in_read_row         (i_in_read_row),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_printed         (o_out_printed),
        .o_out_cursor_column   (o_out_cursor_column),
        .o_out_cursor_row      (o_out_cursor_row),
        .o_out_cell_char       (o_out_cell_char),
        .o_out_cell_foreground (o_out_cell_foreground),
        .o_out_cell_background (o_out_cell_background),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- console predictor ----------------

    task automatic shift_rows_up();
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
        scroll_cnt++;
        heavy_cnt++;
    endtask

    task automatic line_feed();
        cur_col = '0;
        if (int'(cur_row) + 1 >= ROWS) begin
            cur_row = ROW_W'(ROWS - 1);
            shift_rows_up();
        end else begin
            cur_row = cur_row + 1'b1;
        end
    endtask

    task automatic cursor_step();
        cur_col = cur_col + 1'b1;
        if (int'(cur_col) >= COLUMNS) line_feed();
    endtask

    task automatic console_predict(input t_console_cmd c, output t_console_res r);
        t_cell cl;
        int    addr;
        cl = '0;
        r  = '0;
        case (c.op)
            OP_PUT: begin
                if (c.ch == CH_NEWLINE) begin
                    line_feed();
                end else if (c.ch == CH_TAB) begin
                    repeat (TAB_STEPS) cursor_step();
                end else if (c.ch != CH_NUL) begin
                    addr = int'(cur_row) * COLUMNS + int'(cur_col);
                    screen[addr] = '{bg: bg_reg, fg: fg_reg, ch: c.ch};
                    r.printed = 1'b1;
                    cursor_step();
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen[i] = '0;
                cur_col = '0;
                cur_row = '0;
                clear_cnt++;
                heavy_cnt++;
            end
            OP_READ: begin
                if (int'(c.col) < COLUMNS && int'(c.row) < ROWS)
                    cl = screen[int'(c.row) * COLUMNS + int'(c.col)];
            end
            default: ;
        endcase
        r.col = cur_col;
        r.row = cur_row;
        r.ch  = cl.ch;
        r.fg  = cl.fg;
        r.bg  = cl.bg;
    endtask

    // true when the command walks the whole cell store (scroll or clear)
    function automatic bit walks_store(input t_console_cmd c);
        bit last_row;
        last_row = (int'(cur_row) == ROWS - 1);
        if (c.op == OP_CLEAR) return 1'b1;
        if (c.op != OP_PUT || !last_row) return 1'b0;
        if (c.ch == CH_NEWLINE) return 1'b1;
        if (c.ch == CH_TAB) return int'(cur_col) + TAB_STEPS >= COLUMNS;
        return c.ch != CH_NUL && int'(cur_col) == COLUMNS - 1;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_visible();
        logic [CHAR_W-1:0] v;
        do v = CHAR_W'($urandom_range(1, 255)); while (v == CH_TAB || v == CH_NEWLINE);
        return v;
    endfunction

    function automatic t_console_cmd put_cmd(input logic [CHAR_W-1:0] ch);
        t_console_cmd c;
        c.op  = OP_PUT;
        c.ch  = ch;
        c.col = COL_W'($urandom_range(0, 127));
        c.row = ROW_W'($urandom_range(0, 31));
        return c;
    endfunction

    // reads mostly land on text that was just written
    function automatic t_console_cmd read_near();
        t_console_cmd c;
        int           r;
        int           lo;
        r     = $urandom_range(0, 9);
        c.op  = OP_READ;
        c.ch  = CHAR_W'($urandom_range(0, 255));
        c.col = COL_W'($urandom_range(0, COLUMNS - 1));
        c.row = ROW_W'($urandom_range(0, ROWS - 1));
        if (r < 4) begin
            c.col = (cur_col == 0) ? '0 : cur_col - 1'b1;
            c.row = cur_row;
        end else if (r < 8) begin
            lo    = (int'(cur_row) < 3) ? 0 : int'(cur_row) - 3;
            c.row = ROW_W'($urandom_range(lo, int'(cur_row)));
        end
        return c;
    endfunction

    task automatic send_cmd(input t_console_cmd c, input logic typed,
                            input t_console_res typed_res);
        int           gap;
        t_console_res r;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in_operation   <= c.op;
        i_in_char_code   <= c.ch;
        i_in_read_column <= c.col;
        i_in_read_row    <= c.row;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        console_predict(c, r);
        pending_res.push_back(typed ? typed_res : r);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue(input t_console_cmd c);
        // keep the number of full-store walks bounded
        if (heavy_cnt >= HEAVY_BUDGET && walks_store(c)) begin
            c.op  = OP_READ;
            c.col = COL_W'($urandom_range(0, COLUMNS - 1));
            c.row = ROW_W'($urandom_range(0, ROWS - 1));
        end
        if (!(c.op == OP_UNUSED || (c.op == OP_PUT && c.ch == CH_NUL))) rand_done++;
        send_cmd(c, 1'b0, '0);
    endtask

    task automatic run_sequence();
        int           kind;
        int           n;
        t_console_cmd c;
        calm = ($urandom_range(0, 9) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
            repeat (n) issue(put_cmd(pick_visible()));
            if ($urandom_range(0, 9) < 7) issue(put_cmd(CH_NEWLINE));
        end else if (kind < 50) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 5);
            repeat (n) issue(put_cmd(CH_NEWLINE));
        end else if (kind < 60) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                issue(put_cmd(CH_TAB));
                if ($urandom_range(0, 1)) issue(put_cmd(pick_visible()));
            end
        end else if (kind < 82) begin
            n = $urandom_range(1, 6);
            repeat (n) issue(read_near());
        end else if (kind < 84) begin
            c    = put_cmd(CH_NUL);
            c.op = OP_CLEAR;
            issue(c);
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) begin
                c.op  = OP_W'($urandom_range(0, 3));
                c.ch  = CHAR_W'($urandom_range(0, 255));
                c.col = COL_W'($urandom_range(0, 127));
                c.row = ROW_W'($urandom_range(0, 31));
                issue(c);
            end
        end
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CLR_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FOREGROUND) fg_reg = val;
        else bg_reg = val;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ---------------- receiver side ----------------

    always @(negedge i_clk) begin : out_pacing
        int r;
        if (stall_left > 0) begin
            stall_left--;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_out_stall <= 1'b0;
                stall_left  = $urandom_range(0, 6);
            end else if (r < 92) begin
                i_out_stall <= 1'b1;
                stall_left  = $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  = $urandom_range(10, 60);
            end
        end
    end

    task automatic check_field(input string nm, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", nm, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : res_check
        t_console_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_res.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_cnt++;
            end else begin
                want = pending_res.pop_front();
                check_field("printed", 8'(want.printed), 8'(o_out_printed));
                check_field("cursor_column", 8'(want.col), 8'(o_out_cursor_column));
                check_field("cursor_row", 8'(want.row), 8'(o_out_cursor_row));
                check_field("cell_char", want.ch, o_out_cell_char);
                check_field("cell_foreground", 8'(want.fg), 8'(o_out_cell_foreground));
                check_field("cell_background", 8'(want.bg), 8'(o_out_cell_background));
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("text_console_writer_core regression: fail");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        logic [CLR_W-1:0] fgv;
        logic [CLR_W-1:0] bgv;
        int               target;
        for (int i = 0; i < CELLS; i++) screen[i] = '0;
        cur_col = '0;
        cur_row = '0;
        fg_reg  = FG_RESET;
        bg_reg  = BG_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_N; k++)
            send_cmd(stim_tab[k].cmd, stim_tab[k].typed, stim_tab[k].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            fgv = (ph == PHASES - 1) ? CLR_W'($urandom_range(0, 15)) : fg_plan[ph];
            bgv = (ph == PHASES - 1) ? CLR_W'($urandom_range(0, 15)) : bg_plan[ph];
            write_reg(REG_FOREGROUND, fgv);
            write_reg(REG_BACKGROUND, bgv);
            target = RAND_ITEMS * (ph + 1) / PHASES;
            while (rand_done < target) run_sequence();
        end

        calm = 1'b0;
        wait_drained();

        $display("sent %0d items, checked %0d results over %0d colour settings",
                 items_sent, results_seen, PHASES + 1);
        $display("store walks: %0d scrolls, %0d clears; %0d mismatches",
                 scroll_cnt, clear_cnt, fail_cnt);
        if (fail_cnt == 0 && pending_res.size() == 0)
            $display("text_console_writer_core regression: pass");
        else
            $display("text_console_writer_core regression: fail");
        $finish;
    end

endmodule
